// ----- src/gd3_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gd3_pkg
// Shared constants, types and helpers for the 3x3 grayscale dilation unit.
// ----------------------------------------------------------------------------
package gd3_pkg;

   localparam int MAX_LINE   = 1024;
   localparam int MAX_ROWS   = 1024;
   localparam int PIXEL_BITS = 8;

   localparam int PIX_W   = 8;
   localparam int COORD_W = 10;
   localparam int CSR_W   = 11;
   localparam int CSR_AW  = 2;
   localparam int LINE_AW = $clog2(MAX_LINE);
   localparam int ROW_AW  = $clog2(MAX_ROWS);

   localparam logic [CSR_AW-1:0] CSR_LINE_LENGTH = CSR_AW'(0);
   localparam logic [CSR_AW-1:0] CSR_LINE_COUNT  = CSR_AW'(1);
   localparam logic [CSR_AW-1:0] CSR_ENABLE      = CSR_AW'(2);

   localparam logic [CSR_W-1:0] LINE_LENGTH_RST = CSR_W'(100);
   localparam logic [CSR_W-1:0] LINE_COUNT_RST  = CSR_W'(100);
   localparam logic [CSR_W-1:0] MIN_SIZE        = CSR_W'(3);

   typedef logic [PIXEL_BITS-1:0] pix_type;

   typedef struct packed {
      logic                en;
      logic [LINE_AW-1:0] addr;
      pix_type            pix;
   } lstore_rd_type;

   typedef struct packed {
      logic                en;
      logic [LINE_AW-1:0] addr;
      pix_type            data;
   } lstore_wr_type;

   typedef struct packed {
      logic [PIX_W-1:0]   value;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic               last;
   } result_type;

   // last column index, size saturated into 3..MAX_LINE
   function automatic logic [LINE_AW-1:0] last_col(input logic [CSR_W-1:0] v);
      logic [LINE_AW-1:0] res;
      if (v < MIN_SIZE) begin
         res = LINE_AW'(2);
      end else if (int'(v) > MAX_LINE) begin
         res = LINE_AW'(MAX_LINE - 1);
      end else begin
         res = LINE_AW'(v - CSR_W'(1));
      end
      return res;
   endfunction

   // last row index, size saturated into 3..MAX_ROWS
   function automatic logic [ROW_AW-1:0] last_row(input logic [CSR_W-1:0] v);
      logic [ROW_AW-1:0] res;
      if (v < MIN_SIZE) begin
         res = ROW_AW'(2);
      end else if (int'(v) > MAX_ROWS) begin
         res = ROW_AW'(MAX_ROWS - 1);
      end else begin
         res = ROW_AW'(v - CSR_W'(1));
      end
      return res;
   endfunction

endpackage

// ----- src/gd3_line_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gd3_line_store
// Two line memories holding rows r-2 and r-1, with registered read data.
// ----------------------------------------------------------------------------
module gd3_line_store
   import gd3_pkg::*;
(
   input  logic          clock,
   input  lstore_rd_type rd,
   input  lstore_wr_type up_wr,
   output pix_type       up_rd,
   output pix_type       lo_rd
);

   pix_type upper_mem [MAX_LINE];
   pix_type lower_mem [MAX_LINE];
   pix_type up_rd_ff;
   pix_type lo_rd_ff;

   // lower row: read old entry and overwrite it with the new pixel
   always_ff @(posedge clock) begin
      if (rd.en) begin
         lo_rd_ff            <= lower_mem[rd.addr];
         lower_mem[rd.addr] <= rd.pix;
      end
   end

   // upper row: written as the stage register advances, with the old lower-row entry
   always_ff @(posedge clock) begin
      if (rd.en) begin
         up_rd_ff <= upper_mem[rd.addr];
      end
      if (up_wr.en) begin
         upper_mem[up_wr.addr] <= up_wr.data;
      end
   end

   assign up_rd = up_rd_ff;
   assign lo_rd = lo_rd_ff;

endmodule

// ----- src/grayscale_dilation_3x3_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grayscale_dilation_3x3_unit
// 3x3 max filter over a raster pixel stream, border pixels forced to zero.
// ----------------------------------------------------------------------------
// Pixels enter in raster order on the req_ channel, one beat per pixel.
// Each beat yields zero, one or two rsp_ beats tagged with row and column;
// rsp_last marks the final beat caused by a pixel. The first row yields
// none, rows 1..H-2 one each (the pixel one row up and one column left),
// and the last row two each (that pixel and the last row's border pixel).
// With enable cleared every pixel comes back unchanged at its own position.
// A pixel's result passes the stage register, then the output register, with
// the line-store read between; a busy output buffer holds it in the stage.
// Throughput: one pixel per cycle while rsp_stall stays low; in the last row
// the single output port slows it, as each pixel yields two beats. A two-entry
// output buffer and the stage register let the next pixel be taken while a
// result waits on rsp_stall; req_stall rises only once both are occupied.
// Reset clears the position counters, the window and the output buffer and
// loads the register defaults; the line memories are not cleared.
// User writes sizes and enable via csr_ only while idle; the unit never checks.
// ----------------------------------------------------------------------------
module grayscale_dilation_3x3_unit
   import gd3_pkg::*;
(
   input  logic               clock,
   input  logic               reset,

   input  logic               csr_we,
   input  logic [CSR_AW-1:0]  csr_index,
   input  logic [CSR_W-1:0]   csr_wdata,

   input  logic               req_valid,
   output logic               req_stall,
   input  logic [PIX_W-1:0]   req_pixel,

   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [PIX_W-1:0]   rsp_value,
   output logic [COORD_W-1:0] rsp_row,
   output logic [COORD_W-1:0] rsp_col,
   output logic               rsp_last
);

   logic [CSR_W-1:0]   line_length_ff;
   logic [CSR_W-1:0]   line_count_ff;
   logic               enable_ff;

   logic [LINE_AW-1:0] col_count_ff, col_count_in;
   logic [ROW_AW-1:0]  row_count_ff, row_count_in;

   logic [LINE_AW-1:0] wm1, c_cur, c_prev;
   logic [ROW_AW-1:0]  hm1, r_cur;
   pix_type            p_cur;
   logic               req_accept, rsp_accept, s1_adv, out_free;

   logic               s1_valid_ff, s1_valid_in;
   pix_type            s1_pix_ff;
   logic [LINE_AW-1:0] s1_col_ff;
   logic               s1_pass_ff, s1_use_max_ff, s1_a_valid_ff, s1_b_valid_ff;
   logic [ROW_AW-1:0]  s1_a_row_ff, s1_b_row_ff;
   logic [LINE_AW-1:0] s1_a_col_ff, s1_b_col_ff;

   pix_type            win_ff [6];
   pix_type            up_rd, lo_rd, win_max;
   pix_type            a_value;

   lstore_rd_type      ls_rd;
   lstore_wr_type      ls_wr;

   logic [1:0]         out_cnt_ff, out_cnt_in;
   result_type         slot0_ff, slot1_ff, res_a, res_b;

   // ---- configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         line_length_ff <= LINE_LENGTH_RST;
         line_count_ff  <= LINE_COUNT_RST;
         enable_ff      <= 1'b1;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LINE_LENGTH: line_length_ff <= csr_wdata;
            CSR_LINE_COUNT:  line_count_ff  <= csr_wdata;
            CSR_ENABLE:      enable_ff      <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // ---- position and handshake
   assign wm1   = last_col(line_length_ff);
   assign hm1   = last_row(line_count_ff);
   assign c_cur = (col_count_ff > wm1) ? wm1 : col_count_ff;
   assign r_cur = (row_count_ff > hm1) ? hm1 : row_count_ff;
   assign p_cur = req_pixel[PIXEL_BITS-1:0];
   assign c_prev = (c_cur == '0) ? wm1 : LINE_AW'(c_cur - 1'b1);

   assign rsp_valid  = (out_cnt_ff != 2'd0);
   assign rsp_accept = rsp_valid && !rsp_stall;
   assign out_free   = (out_cnt_ff == 2'd0) || ((out_cnt_ff == 2'd1) && rsp_accept);
   assign s1_adv     = s1_valid_ff && (!s1_a_valid_ff || out_free);
   assign req_stall  = s1_valid_ff && !s1_adv;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      col_count_in = col_count_ff;
      row_count_in = row_count_ff;
      if (req_accept) begin
         if (c_cur >= wm1) begin
            col_count_in = '0;
            row_count_in = (r_cur >= hm1) ? '0 : ROW_AW'(r_cur + 1'b1);
         end else begin
            col_count_in = LINE_AW'(c_cur + 1'b1);
            row_count_in = r_cur;
         end
      end
      s1_valid_in = req_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff <= '0;
         row_count_ff <= '0;
         s1_valid_ff  <= 1'b0;
      end else begin
         col_count_ff <= col_count_in;
         row_count_ff <= row_count_in;
         s1_valid_ff  <= s1_valid_in;
      end
   end

   // stage register: result tags worked out on entry
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_pix_ff     <= p_cur;
         s1_col_ff     <= c_cur;
         s1_pass_ff    <= !enable_ff;
         s1_use_max_ff <= enable_ff && (r_cur >= ROW_AW'(2)) && (c_cur >= LINE_AW'(2));
         s1_a_valid_ff <= !enable_ff || (r_cur != '0);
         s1_b_valid_ff <= enable_ff && (r_cur != '0) && (r_cur == hm1);
         s1_a_row_ff   <= enable_ff ? ROW_AW'(r_cur - 1'b1) : r_cur;
         s1_a_col_ff   <= enable_ff ? c_prev : c_cur;
         s1_b_row_ff   <= r_cur;
         s1_b_col_ff   <= c_prev;
      end
   end

   // ---- line store
   assign ls_rd.en   = req_accept;
   assign ls_rd.addr = c_cur;
   assign ls_rd.pix  = p_cur;
   assign ls_wr.en   = s1_adv;
   assign ls_wr.addr = s1_col_ff;
   assign ls_wr.data = lo_rd;

   gd3_line_store u_line_store (
      .clock (clock),
      .rd    (ls_rd),
      .up_wr (ls_wr),
      .up_rd (up_rd),
      .lo_rd (lo_rd)
   );

   // ---- 3x3 maximum
   always_comb begin
      win_max = s1_pix_ff;
      if (up_rd > win_max) win_max = up_rd;
      if (lo_rd > win_max) win_max = lo_rd;
      for (int i = 0; i < 6; i++) begin
         if (win_ff[i] > win_max) win_max = win_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) win_ff[i] <= '0;
      end else if (s1_adv) begin
         win_ff[3] <= win_ff[0];
         win_ff[4] <= win_ff[1];
         win_ff[5] <= win_ff[2];
         win_ff[0] <= up_rd;
         win_ff[1] <= lo_rd;
         win_ff[2] <= s1_pix_ff;
      end
   end

   always_comb begin
      a_value = s1_pass_ff ? s1_pix_ff : (s1_use_max_ff ? win_max : '0);
      res_a.value = PIX_W'(a_value);
      res_a.row   = COORD_W'(s1_a_row_ff);
      res_a.col   = COORD_W'(s1_a_col_ff);
      res_a.last  = !s1_b_valid_ff;
      res_b.value = '0;
      res_b.row   = COORD_W'(s1_b_row_ff);
      res_b.col   = COORD_W'(s1_b_col_ff);
      res_b.last  = 1'b1;
   end

   // ---- output buffer, two beats deep
   always_comb begin
      out_cnt_in = out_cnt_ff;
      if (s1_adv && s1_a_valid_ff) begin
         out_cnt_in = s1_b_valid_ff ? 2'd2 : 2'd1;
      end else if (rsp_accept) begin
         out_cnt_in = 2'(out_cnt_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_cnt_ff <= 2'd0;
      end else begin
         out_cnt_ff <= out_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_a_valid_ff) begin
         slot0_ff <= res_a;
         slot1_ff <= res_b;
      end else if (rsp_accept) begin
         slot0_ff <= slot1_ff;
      end
   end

   assign rsp_value = slot0_ff.value;
   assign rsp_row   = slot0_ff.row;
   assign rsp_col   = slot0_ff.col;
   assign rsp_last  = slot0_ff.last;

   // ---- checks
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      out_cnt_ff != 2'd3)
      else $error("output buffer count out of range");

   a_pair_not_last: assert property (@(posedge clock) disable iff (reset)
      out_cnt_ff == 2'd2 |-> !rsp_last)
      else $error("first beat of a pair flagged last");

   a_pair_load: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_a_valid_ff && s1_b_valid_ff) |=> out_cnt_ff == 2'd2)
      else $error("result pair not loaded");

   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("input stalled with empty stage");

   a_col_step: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (col_count_ff == '0) ||
                     (col_count_ff == LINE_AW'($past(c_cur) + 1'b1)))
      else $error("column counter skipped");

endmodule

// ----- bench/tb_grayscale_dilation_3x3_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grayscale_dilation_3x3_unit
// Self-checking bench for the 3x3 grayscale dilation unit.
// ----------------------------------------------------------------------------
// Pixel frames are streamed in raster order under random sender gaps and
// receiver stalls. A behavioral max-filter tracks line stores, window and
// position, and queues the beats each pixel must produce; every result beat
// is checked field by field against the oldest queued beat. Covers small and
// saturated sizes, pass-through, repeated frames, mid-frame size shrinks
// and oversized line length and line count writes.
// ----------------------------------------------------------------------------
import gd3_pkg::*;

class dilation_checker;
   logic [CSR_W-1:0] width_reg;
   logic [CSR_W-1:0] height_reg;
   logic             en_reg;
   pix_type          upper_mem [MAX_LINE];
   pix_type          lower_mem [MAX_LINE];
   pix_type          win [6];
   int unsigned      col_pos;
   int unsigned      row_pos;
   result_type       due_q [$];
   int               errors;
   int               pixels;
   int               beats;

   function new();
      width_reg  = LINE_LENGTH_RST;
      height_reg = LINE_COUNT_RST;
      en_reg     = 1'b1;
      foreach (upper_mem[i]) begin
         upper_mem[i] = '0;
         lower_mem[i] = '0;
      end
      foreach (win[i]) win[i] = '0;
      col_pos = 0;
      row_pos = 0;
      errors  = 0;
      pixels  = 0;
      beats   = 0;
   endfunction

   function void write_reg(logic [CSR_AW-1:0] idx, logic [CSR_W-1:0] data);
      case (idx)
         CSR_LINE_LENGTH: width_reg = data;
         CSR_LINE_COUNT:  height_reg = data;
         CSR_ENABLE:      en_reg = data[0];
         default: ;
      endcase
   endfunction

   function int unsigned sat_size(logic [CSR_W-1:0] v, int unsigned hi);
      if (v < MIN_SIZE) return int'(MIN_SIZE);
      if (v > hi) return hi;
      return v;
   endfunction

   function result_type make_beat(pix_type v, int unsigned r, int unsigned c);
      result_type b;
      b.value = v;
      b.row   = COORD_W'(r);
      b.col   = COORD_W'(c);
      b.last  = 1'b0;
      return b;
   endfunction

   function bit at_frame_start();
      return col_pos == 0 && row_pos == 0;
   endfunction

   function void take_pixel(pix_type px);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      int unsigned r;
      pix_type     up;
      pix_type     lo;
      pix_type     mx;
      result_type  fresh [$];
      w = sat_size(width_reg, MAX_LINE);
      h = sat_size(height_reg, MAX_ROWS);
      c = (col_pos > w - 1) ? w - 1 : col_pos;
      r = (row_pos > h - 1) ? h - 1 : row_pos;
      up = upper_mem[c];
      lo = lower_mem[c];
      mx = px;
      if (up > mx) mx = up;
      if (lo > mx) mx = lo;
      foreach (win[i]) if (win[i] > mx) mx = win[i];

      if (!en_reg) begin
         fresh.insert(fresh.size(), make_beat(px, r, c));
      end else if (r >= 1) begin
         if (c == 0) begin
            fresh.insert(fresh.size(), make_beat(pix_type'(0), r - 1, w - 1));
         end else begin
            fresh.insert(fresh.size(),
                         make_beat((r >= 2 && c >= 2) ? mx : pix_type'(0), r - 1, c - 1));
         end
         // last row: its border beat rides along
         if (r == h - 1)
            fresh.insert(fresh.size(),
                         make_beat(pix_type'(0), r, (c == 0) ? w - 1 : c - 1));
      end
      if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
      foreach (fresh[i]) due_q.insert(due_q.size(), fresh[i]);

      win[3] = win[0];
      win[4] = win[1];
      win[5] = win[2];
      win[0] = up;
      win[1] = lo;
      win[2] = px;
      upper_mem[c] = lo;
      lower_mem[c] = px;
      if (c >= w - 1) begin
         col_pos = 0;
         row_pos = (r >= h - 1) ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
         row_pos = r;
      end
      pixels++;
   endfunction

   function void check_beat(result_type got);
      result_type want;
      if (due_q.size() == 0) begin
         errors++;
         if (errors <= 10)
            $display("unexpected beat: value %0d row %0d col %0d last %0b",
                     got.value, got.row, got.col, got.last);
         return;
      end
      want = due_q.pop_front();
      beats++;
      if (got.value !== want.value || got.row !== want.row ||
          got.col !== want.col || got.last !== want.last) begin
         errors++;
         if (errors <= 10)
            $display({"beat %0d: exp value %0d row %0d col %0d last %0b, ",
                      "got value %0d row %0d col %0d last %0b"},
                     beats, want.value, want.row, want.col, want.last,
                     got.value, got.row, got.col, got.last);
      end
   endfunction

   function void close();
      if (due_q.size() > 0) begin
         $display("%0d expected beats never arrived", due_q.size());
         errors += due_q.size();
      end
   endfunction
endclass

module tb_grayscale_dilation_3x3_unit;

   typedef enum int {PACE_FULL, PACE_LIGHT, PACE_HEAVY} pace_type;
   typedef enum int {TEX_NOISE, TEX_SPARSE, TEX_BRIGHT} texture_type;

   localparam logic [CSR_AW-1:0] CSR_UNUSED = CSR_AW'(3);

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               csr_we    = 1'b0;
   logic [CSR_AW-1:0]  csr_index = '0;
   logic [CSR_W-1:0]   csr_wdata = '0;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [PIX_W-1:0]   req_pixel = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [PIX_W-1:0]   rsp_value;
   logic [COORD_W-1:0] rsp_row;
   logic [COORD_W-1:0] rsp_col;
   logic               rsp_last;

   dilation_checker sb = new();
   pace_type        tx_pace = PACE_FULL;
   pace_type        rx_pace = PACE_FULL;
   texture_type     texture = TEX_NOISE;
   int              frames_done = 0;

   grayscale_dilation_3x3_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_pixel (req_pixel),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_value (rsp_value),
      .rsp_row   (rsp_row),
      .rsp_col   (rsp_col),
      .rsp_last  (rsp_last)
   );

   always #10 clock = ~clock;

   function automatic int idle_draw(pace_type p);
      case (p)
         PACE_FULL:  return 0;
         PACE_LIGHT: return ($urandom_range(0, 4) == 0) ? int'($urandom_range(0, 17)) : 0;
         default:    return $urandom_range(0, 17);
      endcase
   endfunction

   function automatic pix_type draw_pixel(texture_type t);
      case (t)
         TEX_SPARSE: return ($urandom_range(0, 9) == 0) ? pix_type'($urandom_range(0, 255)) : '0;
         TEX_BRIGHT: return ($urandom_range(0, 9) == 0) ? pix_type'($urandom_range(0, 255))
                                                        : pix_type'(255 - $urandom_range(0, 3));
         default:    return pix_type'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [CSR_W-1:0] pick_size(int unsigned hi);
      if ($urandom_range(0, 9) == 0) return CSR_W'($urandom_range(0, 2));
      return CSR_W'($urandom_range(3, hi));
   endfunction

   // all tasks start and end just after a falling edge
   task automatic write_csr(logic [CSR_AW-1:0] idx, logic [CSR_W-1:0] data);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(negedge clock);
      csr_we = 1'b0;
      sb.write_reg(idx, data);
   endtask

   task automatic send_pixel(pix_type px);
      int gap;
      gap = idle_draw(tx_pace);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_pixel = px;
      do @(posedge clock); while (req_stall);
      sb.take_pixel(px);
      if (sb.at_frame_start()) frames_done++;
      @(negedge clock);
   endtask

   task automatic feed_to_frame_end();
      do send_pixel(draw_pixel(texture)); while (!sb.at_frame_start());
   endtask

   // wait until every queued beat is back, then let beat-less pixels flush
   task automatic settle();
      req_valid = 1'b0;
      while (sb.due_q.size() != 0) @(negedge clock);
      repeat (6) @(negedge clock);
   endtask

   initial begin : rsp_side
      int         hold;
      result_type got;
      while (reset) @(negedge clock);
      forever begin
         hold = idle_draw(rx_pace);
         if (hold > 0) begin
            rsp_stall = 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall = 1'b0;
         do @(posedge clock); while (!rsp_valid);
         got.value = rsp_value;
         got.row   = rsp_row;
         got.col   = rsp_col;
         got.last  = rsp_last;
         sb.check_beat(got);
         @(negedge clock);
      end
   end

   initial begin : stimulus
      pix_type corner_mix [9] = '{8'd0, 8'd255, 8'd0, 8'd1, 8'd254, 8'd2, 8'd128, 8'd127, 8'd0};
      pix_type stripes [9] = '{8'd255, 8'd0, 8'd170, 8'd85, 8'd15, 8'd240, 8'd0, 8'd255, 8'd1};
      int      base;
      int      en;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // smallest frame, sizes written below the minimum
      write_csr(CSR_LINE_LENGTH, CSR_W'(0));
      write_csr(CSR_LINE_COUNT, CSR_W'(2));
      write_csr(CSR_ENABLE, CSR_W'(1));
      foreach (corner_mix[i]) send_pixel(corner_mix[i]);
      settle();

      // pass-through; enable takes bit 0 only
      write_csr(CSR_ENABLE, CSR_W'(11'h7FE));
      write_csr(CSR_LINE_LENGTH, CSR_W'(3));
      write_csr(CSR_LINE_COUNT, CSR_W'(1));
      write_csr(CSR_UNUSED, '1);
      tx_pace = PACE_HEAVY;
      rx_pace = PACE_HEAVY;
      foreach (stripes[i]) send_pixel(stripes[i]);
      settle();

      // shrink both sizes in the middle of a frame
      write_csr(CSR_ENABLE, CSR_W'(11'h401));
      write_csr(CSR_LINE_LENGTH, CSR_W'(8));
      write_csr(CSR_LINE_COUNT, CSR_W'(8));
      tx_pace = PACE_LIGHT;
      rx_pace = PACE_LIGHT;
      repeat (29) send_pixel(draw_pixel(texture));
      settle();
      write_csr(CSR_LINE_LENGTH, CSR_W'(5));
      write_csr(CSR_LINE_COUNT, CSR_W'(5));
      feed_to_frame_end();

      base = sb.pixels;
      while (sb.pixels - base < 900) begin
         settle();
         if ($urandom_range(0, 3) != 0) write_csr(CSR_LINE_LENGTH, pick_size(14));
         if ($urandom_range(0, 3) != 0) write_csr(CSR_LINE_COUNT, pick_size(10));
         if ($urandom_range(0, 3) != 0) begin
            en = ($urandom_range(0, 4) != 0);
            write_csr(CSR_ENABLE, CSR_W'(($urandom_range(0, 1023) << 1) | en));
         end
         tx_pace = pace_type'($urandom_range(0, 2));
         rx_pace = pace_type'($urandom_range(0, 2));
         texture = texture_type'($urandom_range(0, 2));
         repeat ($urandom_range(1, 2)) feed_to_frame_end();
      end

      // oversized line length, cut short partway along the first row
      settle();
      tx_pace = PACE_LIGHT;
      rx_pace = PACE_LIGHT;
      texture = TEX_NOISE;
      write_csr(CSR_LINE_LENGTH, '1);
      write_csr(CSR_LINE_COUNT, CSR_W'(3));
      write_csr(CSR_ENABLE, CSR_W'(1));
      repeat (40) send_pixel(draw_pixel(texture));
      settle();
      write_csr(CSR_LINE_LENGTH, CSR_W'(6));
      feed_to_frame_end();

      // oversized line count, cut short after a few rows
      settle();
      write_csr(CSR_LINE_LENGTH, CSR_W'(3));
      write_csr(CSR_LINE_COUNT, '1);
      repeat (15) send_pixel(draw_pixel(texture));
      settle();
      write_csr(CSR_LINE_COUNT, CSR_W'(4));
      feed_to_frame_end();

      settle();
      repeat (10) @(negedge clock);
      sb.close();
      $display("%0d pixels over %0d frames, %0d result beats checked",
               sb.pixels, frames_done, sb.beats);
      $display("sizes from 3x3 up, oversized writes, dilate and pass modes, mid-frame shrinks");
      if (sb.errors == 0) begin
         $display("grayscale_dilation_3x3_unit: match");
      end else begin
         $display("grayscale_dilation_3x3_unit: mismatch");
      end
      $finish;
   end

   initial begin : watchdog
      #25_000_000;
      $display("timeout with %0d beats outstanding", sb.due_q.size());
      $display("grayscale_dilation_3x3_unit: mismatch");
      $finish;
   end

endmodule

// ----- files.f -----
src/gd3_pkg.sv
src/gd3_line_store.sv
src/grayscale_dilation_3x3_unit.sv
bench/tb_grayscale_dilation_3x3_unit.sv
